FILE: design/schlick_fresnel_with_tir_unit_defines.svh
// Assertion shorthands for the Fresnel unit; they expect clk and rst_n in scope.
`ifndef SCHLICK_FRESNEL_WITH_TIR_UNIT_DEFINES_SVH
`define SCHLICK_FRESNEL_WITH_TIR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SFR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr: implication violated");

// expression must never be true
`define SFR_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sfr: forbidden condition seen");

`endif

FILE: design/sfr_pkg.sv
package sfr_pkg;

    localparam int MAG_W = 17;
    localparam int CFG_W = 16;

    typedef enum logic [1:0] {
        REG_IOR_OUTER   = 2'd0,
        REG_IOR_INNER   = 2'd1,
        REG_BASE_REFL   = 2'd2,
        REG_INDEX_RATIO = 2'd3
    } reg_idx_t;

    localparam logic [CFG_W-1:0] IOR_OUTER_RST   = 16'd4096;
    localparam logic [CFG_W-1:0] IOR_INNER_RST   = 16'd6144;
    localparam logic [CFG_W-1:0] BASE_REFL_RST   = 16'd2621;
    localparam logic [CFG_W-1:0] INDEX_RATIO_RST = 16'd43691;

    // 1.0 in Q.30
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // control and side data that travel alongside each beat
    typedef struct packed {
        logic             valid;
        logic             leaving;
        logic             tir;
        logic [MAG_W-1:0] mag;
    } side_t;

endpackage

FILE: design/sfr_div.sv
module sfr_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfr_pkg::side_t       side_in,
    input  logic [32:0]          num,
    input  logic [31:0]          den,
    output sfr_pkg::side_t       side_out,
    output logic [FRAC_BITS-1:0] quot
);

    localparam int N     = FRAC_BITS;
    localparam int REM_W = 33;

    sfr_pkg::side_t     side_reg [0:N-1];
    sfr_pkg::side_t     side_cur [0:N-1];
    logic [REM_W-1:0]   rem_reg  [0:N-1];
    logic [REM_W-1:0]   rem_cur  [0:N-1];
    logic [REM_W-1:0]   rem_next [0:N-1];
    logic [N-1:0]       q_reg    [0:N-1];
    logic [N-1:0]       q_cur    [0:N-1];
    logic [N-1:0]       q_next   [0:N-1];

    // restoring division, one quotient bit/stage; user keeps den static in flight (unchecked)
    always_comb
    begin
        logic [REM_W:0] trial;
        logic [REM_W:0] den_x;
        den_x = {2'b00, den};
        side_cur[0] = side_in;
        rem_cur[0]  = num;
        q_cur[0]    = '0;
        for (int k = 1; k < N; k++)
        begin
            side_cur[k] = side_reg[k-1];
            rem_cur[k]  = rem_reg[k-1];
            q_cur[k]    = q_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            trial = {rem_cur[k], 1'b0};
            if (trial >= den_x)
            begin
                rem_next[k] = REM_W'(trial - den_x);
                q_next[k]   = {q_cur[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = REM_W'(trial);
                q_next[k]   = {q_cur[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                side_reg[k] <= side_cur[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
        end
    end

    assign side_out = side_reg[N-1];
    assign quot     = q_reg[N-1];

endmodule

FILE: design/sfr_sqrt.sv
module sfr_sqrt #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfr_pkg::side_t       side_in,
    input  logic [FRAC_BITS-1:0] sin2,
    output sfr_pkg::side_t       side_out,
    output logic [FRAC_BITS:0]   root
);

    localparam int N   = FRAC_BITS + 1;
    localparam int V_W = 2 * FRAC_BITS + 1;
    localparam int R_W = 2 * FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    sfr_pkg::side_t   side_reg [0:N-1];
    sfr_pkg::side_t   side_cur [0:N-1];
    logic [V_W-1:0]   v_reg    [0:N-1];
    logic [V_W-1:0]   v_cur    [0:N-1];
    logic [V_W-1:0]   v_next   [0:N-1];
    logic [R_W-1:0]   res_reg  [0:N-1];
    logic [R_W-1:0]   res_cur  [0:N-1];
    logic [R_W-1:0]   res_next [0:N-1];

    // digit-by-digit root of (1 - sin2) << F, one result bit per stage
    always_comb
    begin
        logic [R_W-1:0] bitv;
        logic [R_W-1:0] sum;
        logic [R_W-1:0] v_x;
        side_cur[0] = side_in;
        v_cur[0]    = {ONE - {1'b0, sin2}, {FRAC_BITS{1'b0}}};
        res_cur[0]  = '0;
        for (int k = 1; k < N; k++)
        begin
            side_cur[k] = side_reg[k-1];
            v_cur[k]    = v_reg[k-1];
            res_cur[k]  = res_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            bitv = R_W'(1) << (2 * (FRAC_BITS - k));
            sum  = res_cur[k] + bitv;
            v_x  = {1'b0, v_cur[k]};
            if (v_x >= sum)
            begin
                v_next[k]   = V_W'(v_x - sum);
                res_next[k] = (res_cur[k] >> 1) + bitv;
            end
            else
            begin
                v_next[k]   = v_cur[k];
                res_next[k] = res_cur[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                side_reg[k] <= side_cur[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            v_reg[k]   <= v_next[k];
            res_reg[k] <= res_next[k];
        end
    end

    assign side_out = side_reg[N-1];
    assign root     = res_reg[N-1][FRAC_BITS:0];

endmodule

FILE: design/schlick_fresnel_with_tir_unit.sv
// Schlick Fresnel unit with total internal reflection check. Fully pipelined: a beat may be
// started every cycle (busy stays low); its result is held on the done strobe for one cycle. The
// pipeline depth is set mostly by the bit-per-stage divider (FRAC_BITS stages) and square root
// (FRAC_BITS+1 stages) on the refracted path, plus the power chain; every beat takes the same
// path, so results leave in start order. The receiver cannot stall the unit; results must be
// taken as they appear. The user must write registers only while no beat is in flight; unchecked.
`include "schlick_fresnel_with_tir_unit_defines.svh"

module schlick_fresnel_with_tir_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic signed [15:0] cos_incident,
    output logic               done,
    output logic [16:0]        reflectance,
    output logic               total_internal
);

    localparam int LAT   = 2 * FRAC_BITS + 11;
    localparam int F1    = FRAC_BITS + 1;
    localparam int P_W   = 2 * FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = F1'(1) << FRAC_BITS;

    // configuration
    logic [15:0] ior_outer_reg;
    logic [15:0] ior_inner_reg;
    logic [15:0] base_refl_reg;
    logic [15:0] index_ratio_reg;
    logic [31:0] r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ior_outer_reg   <= sfr_pkg::IOR_OUTER_RST;
            ior_inner_reg   <= sfr_pkg::IOR_INNER_RST;
            base_refl_reg   <= sfr_pkg::BASE_REFL_RST;
            index_ratio_reg <= sfr_pkg::INDEX_RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (sfr_pkg::reg_idx_t'(cfg_index))
                sfr_pkg::REG_IOR_OUTER:   ior_outer_reg   <= cfg_data;
                sfr_pkg::REG_IOR_INNER:   ior_inner_reg   <= cfg_data;
                sfr_pkg::REG_BASE_REFL:   base_refl_reg   <= cfg_data;
                sfr_pkg::REG_INDEX_RATIO: index_ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // r^2 in Q.32, refreshed every cycle from the index ratio register
    always_ff @(posedge clk)
    begin
        r2_reg <= index_ratio_reg * index_ratio_reg;
    end

    assign busy = 1'b0;

    // stage a: magnitude and side
    logic [15:0]    raw;
    logic           neg;
    logic           pos;
    sfr_pkg::side_t side_a_next;
    sfr_pkg::side_t side_a_reg;

    assign raw = cos_incident;

    always_comb
    begin
        neg = raw[15];
        pos = !neg && (raw != 16'd0);
        side_a_next.valid   = start;
        side_a_next.tir     = 1'b0;
        side_a_next.mag     = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        side_a_next.leaving = (pos && (ior_outer_reg > ior_inner_reg))
                           || (neg && (ior_inner_reg > ior_outer_reg));
    end

    // stage b: 1 - c^2 in Q.32
    sfr_pkg::side_t side_b_reg;
    logic [33:0]    mag_sq;
    logic [30:0]    m_q30;
    logic [32:0]    m4_b_reg;

    always_comb
    begin
        mag_sq = side_a_reg.mag * side_a_reg.mag;
        m_q30  = sfr_pkg::ONE_Q30 - mag_sq[30:0];
    end

    // stage c: total internal reflection decision
    sfr_pkg::side_t side_c_next;
    sfr_pkg::side_t side_c_reg;
    logic [32:0]    m4_c_reg;

    always_comb
    begin
        side_c_next     = side_b_reg;
        side_c_next.tir = side_b_reg.leaving && (m4_b_reg >= {1'b0, r2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
        end
        else
        begin
            side_a_reg <= side_a_next;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m4_b_reg <= {m_q30, 2'b00};
        m4_c_reg <= m4_b_reg;
    end

    // sin^2 of refracted angle, then its cosine
    sfr_pkg::side_t         side_d;
    logic [FRAC_BITS-1:0]   sin2;
    sfr_pkg::side_t         side_s;
    logic [FRAC_BITS:0]     root;

    sfr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (side_c_reg),
        .num      (m4_c_reg),
        .den      (r2_reg),
        .side_out (side_d),
        .quot     (sin2)
    );

    sfr_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (side_d),
        .sin2     (sin2),
        .side_out (side_s),
        .root     (root)
    );

    // power chain: stage 0 forms x = 1 - cos, stages 1..4 multiply by x
    logic [FRAC_BITS+16:0] mag_sh;
    logic [FRAC_BITS:0]    cos_direct;
    logic [FRAC_BITS:0]    cos_sel;
    sfr_pkg::side_t        side_p_reg [0:4];
    logic [FRAC_BITS:0]    x_reg      [0:4];
    logic [FRAC_BITS:0]    p_reg      [0:4];
    logic [FRAC_BITS:0]    p_next     [1:4];
    logic [P_W-1:0]        pp         [1:4];

    always_comb
    begin
        mag_sh     = {side_s.mag, {FRAC_BITS{1'b0}}};
        cos_direct = F1'(mag_sh >> 15);
        cos_sel    = side_s.leaving ? root : cos_direct;
        for (int j = 1; j <= 4; j++)
        begin
            pp[j]     = p_reg[j-1] * x_reg[j-1];
            p_next[j] = F1'(pp[j] >> FRAC_BITS);
        end
    end

    // final blend: R = f + (1 - f) * p, or 1.0 on total internal reflection
    logic [FRAC_BITS+15:0] f0_sh;
    logic [FRAC_BITS:0]    f_q;
    sfr_pkg::side_t        side_f_reg;
    logic [P_W-1:0]        blend_reg;
    logic [FRAC_BITS:0]    r_q;
    logic [FRAC_BITS+16:0] r_sh;
    logic [16:0]           refl_next;

    always_comb
    begin
        f0_sh     = {base_refl_reg, {FRAC_BITS{1'b0}}};
        f_q       = F1'(f0_sh >> 16);
        r_q       = f_q + F1'(blend_reg >> FRAC_BITS);
        r_sh      = {r_q, 16'd0};
        refl_next = side_f_reg.tir ? 17'h10000 : 17'(r_sh >> FRAC_BITS);
    end

    logic        done_reg;
    logic        tir_out_reg;
    logic [16:0] refl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= 4; j++)
            begin
                side_p_reg[j] <= '0;
            end
            side_f_reg  <= '0;
            done_reg    <= 1'b0;
            tir_out_reg <= 1'b0;
        end
        else
        begin
            side_p_reg[0] <= side_s;
            for (int j = 1; j <= 4; j++)
            begin
                side_p_reg[j] <= side_p_reg[j-1];
            end
            side_f_reg  <= side_p_reg[4];
            done_reg    <= side_f_reg.valid;
            tir_out_reg <= side_f_reg.valid && side_f_reg.tir;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= ONE - cos_sel;
        p_reg[0] <= ONE - cos_sel;
        for (int j = 1; j <= 4; j++)
        begin
            x_reg[j] <= x_reg[j-1];
            p_reg[j] <= p_next[j];
        end
        blend_reg <= (ONE - f_q) * p_reg[4];
        refl_reg  <= refl_next;
    end

    assign done           = done_reg;
    assign total_internal = tir_out_reg;
    assign reflectance    = refl_reg;

    `SFR_ASSERT_IMPLIES(a_tir_full_refl, done && total_internal, reflectance == 17'h10000)
    `SFR_ASSERT_IMPLIES(a_refl_range, done, reflectance <= 17'h10000)
    `SFR_ASSERT_IMPLIES(a_fixed_latency, done, $past(start, LAT))
    `SFR_ASSERT_NEVER(a_tir_without_beat, total_internal && !done)

endmodule
